// ===== design/ptls_pkg.sv =====
// Shared types, register indexes and lamp codes for the preemptive traffic light sequencer.
package ptls_pkg;

	// Lamp set of one light: bit 0 green, bit 1 yellow, bit 2 red.
	typedef logic [2:0] lamp_t;

	localparam lamp_t LAMP_G = 3'b001;
	localparam lamp_t LAMP_Y = 3'b010;
	localparam lamp_t LAMP_R = 3'b100;

	localparam int TIME_W = 32;
	localparam int ECHO_W = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef logic [TIME_W-1:0] ms_t;
	typedef logic [ECHO_W-1:0] echo_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MEASURE_INTERVAL = 3'd0,
		REG_YELLOW = 3'd1,
		REG_GREEN = 3'd2,
		REG_QUIET = 3'd3,
		REG_ECHO_THRESHOLD = 3'd4
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam ms_t RST_MEASURE_INTERVAL = 32'd2000;
	localparam ms_t RST_YELLOW = 32'd2000;
	localparam ms_t RST_GREEN = 32'd5000;
	localparam ms_t RST_QUIET = 32'd10000;
	localparam echo_t RST_ECHO_THRESHOLD = 20'd291;

	// Clear the lamps in off, then light the lamps in on.
	function automatic lamp_t lamp_set(input lamp_t cur, input lamp_t off, input lamp_t on);
		return (cur & ~off) | on;
	endfunction

endpackage

// ===== design/preemptive_traffic_light_sequencer_unit.sv =====
// Top level of the preemptive traffic light sequencer: input stage, control pass and lamp state.
//
//  channel   direction  handshake                 word
//  in        input      in_valid / in_stall       now_ms, echo_us_first, echo_us_second
//  out       output     out_valid / out_stall     lamps_main, lamps_side_one, lamps_side_two,
//                                                 preempt_active, served_light
//  cfg       input      cfg_wr_en                 cfg_index, cfg_data
//
// One word per cycle is sustained while the output is not stalled. The accepted word is held in
// the input register, and the control pass then writes the lamp state registers, which hold
// the result word.
// The lamp state registers double as the result register, so they update only when the
// result slot is free or being taken. Reset is asynchronous and active low; it sets all
// lamps red, main green flag set, and the configuration registers to their defaults.
// A stalled output holds the input register, and the input stalls only when it is full.
module preemptive_traffic_light_sequencer_unit
	import ptls_pkg::*;
#(
	parameter int NUM_LIGHTS = 3,
	parameter int NUM_SENSORS = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [31:0]          now_ms,
	input  logic [19:0]          echo_us_first,
	input  logic [19:0]          echo_us_second,
	// Output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           lamps_main,
	output logic [2:0]           lamps_side_one,
	output logic [2:0]           lamps_side_two,
	output logic                 preempt_active,
	output logic [1:0]           served_light
);

	localparam int LIGHT_W = $clog2(NUM_LIGHTS);

	// Configuration registers
	ms_t   measure_interval_q, yellow_q, green_q, quiet_q;
	echo_t echo_threshold_q;

	// Input stage
	logic  valid_s1;
	ms_t   now_s1;
	echo_t echo_first_s1, echo_second_s1;

	// Sequencer state
	ms_t                last_sample_q, last_release_q, phase_start_q;
	logic               pending_q, seen_before_q, others_stopped_q;
	logic [LIGHT_W-1:0] light_q;
	logic               green_q_flags [NUM_LIGHTS];
	lamp_t              lamp_q [NUM_LIGHTS];

	// Next state from the control pass
	ms_t                last_sample_d, last_release_d, phase_start_d;
	logic               pending_d, others_stopped_d;
	logic [LIGHT_W-1:0] light_d;
	logic               green_d [NUM_LIGHTS];
	lamp_t              lamp_d [NUM_LIGHTS];

	logic advance;
	logic accept_in;

	// The pass runs when a word waits and the result slot is free or being taken.
	assign advance = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measure_interval_q <= RST_MEASURE_INTERVAL;
			yellow_q <= RST_YELLOW;
			green_q <= RST_GREEN;
			quiet_q <= RST_QUIET;
			echo_threshold_q <= RST_ECHO_THRESHOLD;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MEASURE_INTERVAL: measure_interval_q <= cfg_data;
				REG_YELLOW: yellow_q <= cfg_data;
				REG_GREEN: green_q <= cfg_data;
				REG_QUIET: quiet_q <= cfg_data;
				REG_ECHO_THRESHOLD: echo_threshold_q <= cfg_data[ECHO_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (accept_in) begin
			now_s1 <= now_ms;
			echo_first_s1 <= echo_us_first;
			echo_second_s1 <= echo_us_second;
		end
	end

	// Control pass: sampling, preemption of the other lights, served sequence, main sequence.
	always_comb begin
		ms_t        since_release;
		ms_t        t_stop;
		ms_t        t_main;
		ms_t        t_served;
		logic [32:0] bound_green;
		logic [33:0] bound_end;
		echo_t      echo_i;
		logic       pend_a;
		logic [LIGHT_W-1:0] light_a;
		ms_t        phase_a;
		logic       stopped_now;

		last_sample_d = last_sample_q;
		last_release_d = last_release_q;
		phase_start_d = phase_start_q;
		pending_d = pending_q;
		others_stopped_d = others_stopped_q;
		light_d = light_q;
		for (int i = 0; i < NUM_LIGHTS; i++) begin
			green_d[i] = green_q_flags[i];
			lamp_d[i] = lamp_q[i];
		end
		since_release = now_s1 - last_release_q;
		stopped_now = 1'b0;
		echo_i = '0;
		t_served = '0;
		bound_green = '0;
		bound_end = '0;

		// Sensor sampling; the highest requesting sensor wins.
		pend_a = pending_q;
		light_a = light_q;
		if ((now_s1 - last_sample_q) > measure_interval_q) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				if (i == 0) begin
					echo_i = echo_first_s1;
				end else if (i == 1) begin
					echo_i = echo_second_s1;
				end else begin
					echo_i = '0;
				end
				if ((i + 1 < NUM_LIGHTS) && (echo_i <= echo_threshold_q) &&
				    (since_release >= quiet_q)) begin
					pend_a = 1'b1;
					light_a = LIGHT_W'(i + 1);
				end
			end
			last_sample_d = now_s1;
		end
		pending_d = pend_a;
		light_d = light_a;

		// A new request restarts the phase timer.
		phase_a = (!seen_before_q && pend_a) ? now_s1 : phase_start_q;
		phase_start_d = phase_a;

		t_stop = now_s1 - phase_a;
		t_main = t_stop;

		if (pend_a) begin
			// Bring every other green light through yellow to red.
			if (!others_stopped_q) begin
				if (t_stop < yellow_q) begin
					for (int i = 0; i < NUM_LIGHTS; i++) begin
						if ((LIGHT_W'(i) != light_a) && green_q_flags[i]) begin
							lamp_d[i] = lamp_set(lamp_q[i], LAMP_G, LAMP_Y);
						end
					end
				end else begin
					for (int i = 0; i < NUM_LIGHTS; i++) begin
						if ((LIGHT_W'(i) != light_a) && green_q_flags[i]) begin
							green_d[i] = 1'b0;
							lamp_d[i] = lamp_set(lamp_q[i], LAMP_Y, LAMP_R);
						end
					end
					stopped_now = 1'b1;
					phase_start_d = now_s1;
				end
			end
			others_stopped_d = others_stopped_q || stopped_now;

			// Served light: yellow, green, yellow, then red and release.
			t_served = now_s1 - phase_start_d;
			bound_green = {1'b0, yellow_q} + {1'b0, green_q};
			bound_end = {1'b0, bound_green} + {2'b00, yellow_q};
			for (int i = 0; i < NUM_LIGHTS; i++) begin
				if (LIGHT_W'(i) == light_a) begin
					if (t_served < yellow_q) begin
						lamp_d[i] = lamp_set(lamp_q[i], LAMP_R, LAMP_Y);
					end else if ({1'b0, t_served} < bound_green) begin
						green_d[i] = 1'b1;
						lamp_d[i] = lamp_set(lamp_q[i], LAMP_Y, LAMP_G);
					end else if ({2'b00, t_served} < bound_end) begin
						lamp_d[i] = lamp_set(lamp_q[i], LAMP_G, LAMP_Y);
					end else begin
						green_d[i] = 1'b0;
						lamp_d[i] = lamp_set(lamp_q[i], LAMP_Y, LAMP_R);
					end
				end
			end
			if (!({2'b00, t_served} < bound_end)) begin
				pending_d = 1'b0;
				phase_start_d = now_s1;
				last_release_d = now_s1;
				others_stopped_d = 1'b0;
			end
		end else begin
			// Main road: yellow, then green.
			if (t_main < yellow_q) begin
				lamp_d[0] = lamp_set(lamp_q[0], LAMP_R, LAMP_Y);
			end else begin
				green_d[0] = 1'b1;
				lamp_d[0] = lamp_set(lamp_q[0], LAMP_Y, LAMP_G);
			end
		end
	end

	// Sequencer state; the lamp and request registers are also the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
			last_release_q <= '0;
			phase_start_q <= '0;
			pending_q <= 1'b0;
			seen_before_q <= 1'b0;
			others_stopped_q <= 1'b0;
			light_q <= '0;
			for (int i = 0; i < NUM_LIGHTS; i++) begin
				green_q_flags[i] <= (i == 0);
				lamp_q[i] <= LAMP_R;
			end
		end else if (advance) begin
			last_sample_q <= last_sample_d;
			last_release_q <= last_release_d;
			phase_start_q <= phase_start_d;
			pending_q <= pending_d;
			seen_before_q <= pending_d;
			others_stopped_q <= others_stopped_d;
			light_q <= light_d;
			for (int i = 0; i < NUM_LIGHTS; i++) begin
				green_q_flags[i] <= green_d[i];
				lamp_q[i] <= lamp_d[i];
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Result word
	assign lamps_main = lamp_q[0];
	assign lamps_side_one = lamp_q[1];
	assign preempt_active = pending_q;
	assign served_light = pending_q ? 2'(light_q) : 2'b00;

	generate
		if (NUM_LIGHTS > 2) begin : g_side_two
			assign lamps_side_two = lamp_q[2];
		end else begin : g_no_side_two
			assign lamps_side_two = '0;
		end
	endgenerate

	// A pending request always names a side light.
	a_pending_light: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (light_q != '0))
		else $error("request pending for the main light");

	// The other lights can only be marked stopped while a request is served.
	a_stopped_pending: assert property (@(posedge clk) disable iff (!arst_n)
		others_stopped_q |-> pending_q)
		else $error("others stopped without a pending request");

	// Every pass produces a result word on the next cycle.
	a_advance_valid: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("control pass without a result");

	// The sequencer state moves only with a control pass.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pending_q) && $stable(phase_start_q))
		else $error("sequencer state changed without a pass");

endmodule

// ===== sim/preemptive_traffic_light_sequencer_unit_test.sv =====
// Self-checking testbench for the preemptive traffic light sequencer, with a built-in lamp predictor.
`timescale 1ns / 100ps

module preemptive_traffic_light_sequencer_unit_test;
	import ptls_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;

	// One input word and one result word.
	typedef struct {
		ms_t now;
		echo_t echo_one;
		echo_t echo_two;
	} sensor_word_t;

	typedef struct {
		lamp_t lamps_m;
		lamp_t lamps_s1;
		lamp_t lamps_s2;
		logic active;
		logic [1:0] light;
	} lamp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] now_ms = '0;
	logic [19:0] echo_us_first = '0;
	logic [19:0] echo_us_second = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] lamps_main;
	logic [2:0] lamps_side_one;
	logic [2:0] lamps_side_two;
	logic preempt_active;
	logic [1:0] served_light;

	preemptive_traffic_light_sequencer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_ms(now_ms),
		.echo_us_first(echo_us_first),
		.echo_us_second(echo_us_second),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.lamps_main(lamps_main),
		.lamps_side_one(lamps_side_one),
		.lamps_side_two(lamps_side_two),
		.preempt_active(preempt_active),
		.served_light(served_light)
	);

	always #4 clk = ~clk;

	sensor_word_t pending_words[$];
	lamp_word_t expected_lamps[$];
	int fail_count = 0;
	int stuck_cycles = 0;
	logic in_taken = 1'b0;
	logic calm = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	ms_t clock_ms = '0;

	// Shadow of the configuration registers.
	ms_t interval_cfg, yellow_cfg, green_cfg, quiet_cfg;
	echo_t thresh_cfg;

	// Shadow of the controller state.
	ms_t sample_ms, release_ms, phase_ms;
	logic pending_req, seen_req, others_halted;
	logic [1:0] serve_idx;
	logic green_flag [3];
	lamp_t lamp_now [3];

	task automatic reset_model();
		interval_cfg = RST_MEASURE_INTERVAL;
		yellow_cfg = RST_YELLOW;
		green_cfg = RST_GREEN;
		quiet_cfg = RST_QUIET;
		thresh_cfg = RST_ECHO_THRESHOLD;
		sample_ms = '0;
		release_ms = '0;
		phase_ms = '0;
		pending_req = 1'b0;
		seen_req = 1'b0;
		others_halted = 1'b0;
		serve_idx = '0;
		for (int i = 0; i < 3; i++) begin
			green_flag[i] = (i == 0);
			lamp_now[i] = LAMP_R;
		end
	endtask

	// One control pass: sample the sensors, advance preemption or the main sequence.
	function automatic lamp_word_t next_lamp_state(ms_t now, echo_t e_one, echo_t e_two);
		lamp_word_t res;
		ms_t since_release;
		ms_t elapsed;
		logic [63:0] t64, b1, b2, b3;
		logic stop [3];
		echo_t echo [2];
		since_release = now - release_ms;
		echo[0] = e_one;
		echo[1] = e_two;
		if (ms_t'(now - sample_ms) > interval_cfg) begin
			// Sensor i serves light i+1; the last sensor asking wins.
			for (int i = 0; i < 2; i++)
				if (echo[i] <= thresh_cfg && since_release >= quiet_cfg) begin
					pending_req = 1'b1;
					serve_idx = 2'(i + 1);
				end
			sample_ms = now;
		end
		if (!seen_req && pending_req)
			phase_ms = now;
		if (pending_req) begin
			for (int i = 0; i < 3; i++)
				stop[i] = (i != serve_idx) && green_flag[i];
			// Bring every other green light down through yellow to red.
			if (!others_halted) begin
				elapsed = now - phase_ms;
				if (elapsed < yellow_cfg) begin
					for (int i = 0; i < 3; i++)
						if (stop[i])
							lamp_now[i] = (lamp_now[i] & ~LAMP_G) | LAMP_Y;
				end else begin
					for (int i = 0; i < 3; i++)
						if (stop[i]) begin
							green_flag[i] = 1'b0;
							lamp_now[i] = (lamp_now[i] & ~LAMP_Y) | LAMP_R;
						end
					others_halted = 1'b1;
					phase_ms = now;
				end
			end
			// Served light: yellow, green, yellow, red; bounds do not wrap.
			t64 = {32'd0, ms_t'(now - phase_ms)};
			b1 = {32'd0, yellow_cfg};
			b2 = b1 + {32'd0, green_cfg};
			b3 = b2 + {32'd0, yellow_cfg};
			if (t64 < b1) begin
				lamp_now[serve_idx] = (lamp_now[serve_idx] & ~LAMP_R) | LAMP_Y;
			end else if (t64 < b2) begin
				green_flag[serve_idx] = 1'b1;
				lamp_now[serve_idx] = (lamp_now[serve_idx] & ~LAMP_Y) | LAMP_G;
			end else if (t64 < b3) begin
				lamp_now[serve_idx] = (lamp_now[serve_idx] & ~LAMP_G) | LAMP_Y;
			end else begin
				green_flag[serve_idx] = 1'b0;
				lamp_now[serve_idx] = (lamp_now[serve_idx] & ~LAMP_Y) | LAMP_R;
				pending_req = 1'b0;
				phase_ms = now;
			end
			if (!pending_req) begin
				release_ms = now;
				others_halted = 1'b0;
			end
		end else begin
			// No request: main road goes yellow, then green.
			elapsed = now - phase_ms;
			if (elapsed < yellow_cfg) begin
				lamp_now[0] = (lamp_now[0] & ~LAMP_R) | LAMP_Y;
			end else begin
				green_flag[0] = 1'b1;
				lamp_now[0] = (lamp_now[0] & ~LAMP_Y) | LAMP_G;
			end
		end
		seen_req = pending_req;
		res.lamps_m = lamp_now[0];
		res.lamps_s1 = lamp_now[1];
		res.lamps_s2 = lamp_now[2];
		res.active = pending_req;
		res.light = pending_req ? serve_idx : 2'd0;
		return res;
	endfunction

	// Input side: hold a stalled word, otherwise idle in bursts or send the next word.
	always @(negedge clk) begin
		logic holding;
		holding = in_valid && !in_taken;
		if (!holding) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (!calm && pending_words.size() > 0 && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(1, 17) - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				sensor_word_t w;
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				now_ms <= w.now;
				echo_us_first <= w.echo_one;
				echo_us_second <= w.echo_two;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side: stall in random bursts except in the calm stretch.
	always @(negedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 17) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Predict on each accepted word, check each accepted result, watch for a hang.
	always @(posedge clk) begin
		lamp_word_t want;
		logic progress;
		in_taken = 1'b0;
		progress = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				progress = 1'b1;
				expected_lamps.push_back(next_lamp_state(now_ms, echo_us_first, echo_us_second));
			end
			if (out_valid && !out_stall) begin
				progress = 1'b1;
				if (expected_lamps.size() == 0) begin
					$error("unexpected result word");
					fail_count++;
				end else begin
					want = expected_lamps.pop_front();
					if (lamps_main !== want.lamps_m) begin
						$error("lamps_main: expected %0d, got %0d", want.lamps_m, lamps_main);
						fail_count++;
					end
					if (lamps_side_one !== want.lamps_s1) begin
						$error("lamps_side_one: expected %0d, got %0d", want.lamps_s1,
							lamps_side_one);
						fail_count++;
					end
					if (lamps_side_two !== want.lamps_s2) begin
						$error("lamps_side_two: expected %0d, got %0d", want.lamps_s2,
							lamps_side_two);
						fail_count++;
					end
					if (preempt_active !== want.active) begin
						$error("preempt_active: expected %0d, got %0d", want.active,
							preempt_active);
						fail_count++;
					end
					if (served_light !== want.light) begin
						$error("served_light: expected %0d, got %0d", want.light, served_light);
						fail_count++;
					end
				end
			end
			if (progress) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= WATCHDOG_LIMIT) begin
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	task automatic push_word(ms_t now, echo_t e_one, echo_t e_two);
		sensor_word_t w;
		w.now = now;
		w.echo_one = e_one;
		w.echo_two = e_two;
		pending_words.push_back(w);
		clock_ms = now;
	endtask

	// Echo values clustered around the threshold, plus the field extremes.
	function automatic echo_t pick_echo();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return thresh_cfg;
			2: return thresh_cfg + 20'd1;
			3: return (thresh_cfg == 0) ? '0 : thresh_cfg - 20'd1;
			4: return '1;
			5, 6: return echo_t'($urandom_range(0, thresh_cfg));
			default: return echo_t'($urandom);
		endcase
	endfunction

	// Mostly forward time steps up to span, with occasional jumps and steps back.
	task automatic push_random(int count, ms_t span);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				clock_ms = $urandom;
			else if (r < 6)
				clock_ms = clock_ms - $urandom_range(0, span);
			else
				clock_ms = clock_ms + $urandom_range(0, span);
			push_word(clock_ms, pick_echo(), pick_echo());
		end
	endtask

	// Wait until every word is sent and every result is back, then let the pipe settle.
	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_lamps.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_MEASURE_INTERVAL: interval_cfg = value;
			REG_YELLOW: yellow_cfg = value;
			REG_GREEN: green_cfg = value;
			REG_QUIET: quiet_cfg = value;
			REG_ECHO_THRESHOLD: thresh_cfg = echo_t'(value);
			default: ;
		endcase
	endtask

	task automatic set_timing(ms_t interval, ms_t yellow, ms_t green, ms_t quiet, echo_t thresh);
		write_reg(REG_MEASURE_INTERVAL, interval);
		write_reg(REG_YELLOW, yellow);
		write_reg(REG_GREEN, green);
		write_reg(REG_QUIET, quiet);
		write_reg(REG_ECHO_THRESHOLD, {12'd0, thresh});
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		reset_model();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed pass at reset timing: main yellow then green, a full preemption of
		// side one at the exact threshold, quiet-time refusal, both sensors asking,
		// timed-out echoes, and time wrapping around.
		push_word(32'd0, 20'd0, 20'd0);
		push_word(32'd1999, 20'd0, 20'd0);
		push_word(32'd2000, 20'd0, 20'd0);
		push_word(32'd2001, 20'd0, 20'd0);
		push_word(32'd4000, 20'd500, 20'd500);
		push_word(32'd9999, 20'd0, 20'd0);
		push_word(32'd12000, 20'd291, 20'd292);
		push_word(32'd13000, 20'd292, 20'd292);
		push_word(32'd14000, 20'hFFFFF, 20'hFFFFF);
		push_word(32'd15000, 20'd0, 20'd0);
		push_word(32'd16500, 20'd0, 20'd0);
		push_word(32'd21000, 20'd0, 20'd0);
		push_word(32'd23000, 20'd0, 20'd0);
		push_word(32'd23001, 20'd292, 20'd0);
		push_word(32'd33001, 20'd0, 20'd0);
		push_word(32'd33002, 20'd0, 20'd0);
		push_word(32'd35001, 20'd0, 20'd0);
		push_word(32'd37001, 20'd0, 20'd0);
		push_word(32'd40001, 20'd0, 20'd0);
		push_word(32'd44001, 20'd0, 20'd0);
		push_word(32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF);
		push_word(32'd5, 20'h55555, 20'hAAAAA);
		push_word(32'h7FFF_FFFF, 20'hAAAAA, 20'h55555);
		drain();

		// Short timings so random steps walk through every phase.
		set_timing(32'd5, 32'd10, 32'd20, 32'd30, 20'd291);
		push_random(200, 32'd15);
		drain();

		// All timings zero; the sender also waits for a full drain mid-way.
		set_timing(32'd0, 32'd0, 32'd0, 32'd0, 20'd0);
		push_random(60, 32'd3);
		drain();
		push_random(60, 32'd3);
		drain();

		// All registers at their maximum.
		set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF);
		push_random(40, 32'hFFFF_FFFF);
		drain();

		set_timing(32'd3, 32'd0, 32'd7, 32'd0, 20'd1000);
		push_random(150, 32'd6);
		drain();

		set_timing(32'd50, 32'd4, 32'd1, 32'd100, 20'h80000);
		push_random(150, 32'd40);
		drain();

		// Yellow plus green overflows 32 bits.
		set_timing(32'd1, 32'hFFFF_FFF0, 32'd64, 32'd0, 20'hFFFFF);
		push_random(80, 32'hFFFF_FFFF);
		drain();

		// Reset timing with no idling on either side.
		calm = 1'b1;
		set_timing(32'd2000, 32'd2000, 32'd5000, 32'd10000, 20'd291);
		push_random(200, 32'd1500);
		drain();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== preemptive_traffic_light_sequencer_unit.f =====
design/ptls_pkg.sv
design/preemptive_traffic_light_sequencer_unit.sv
sim/preemptive_traffic_light_sequencer_unit_test.sv
